// ----- rtl/scr_pkg.sv -----
// Shared types and constants for the synchronism check relay.
package scr_pkg;

  localparam int unsigned VOLT_W   = 24;
  localparam int unsigned FREQ_W   = 17;
  localparam int unsigned VLIM_W   = 23;
  localparam int unsigned VLIM2_W  = 46;
  localparam int unsigned TIME_W   = 40;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned SQ_W     = 49;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 64;

  localparam logic [FREQ_W-1:0]  FREQ_LIMIT_RST   = 17'd600;
  localparam logic [VLIM_W-1:0]  VOLT_LIMIT_RST   = 23'd12000;
  localparam logic [VLIM2_W-1:0] VOLT_LIMIT2_RST  = 46'd144000000;
  localparam logic [TIME_W-1:0]  HOLD_PERIOD_RST  = 40'd1200000000;
  localparam logic [2:0]         PHASE_ENABLE_RST = 3'b111;

  typedef enum logic [1:0] {
    REG_FREQ_LIMIT   = 2'd0,
    REG_VOLT_LIMIT   = 2'd1,
    REG_HOLD_PERIOD  = 2'd2,
    REG_PHASE_ENABLE = 2'd3
  } scr_reg_t;

  typedef struct packed {
    logic [1:0]               phase;
    logic signed [VOLT_W-1:0] from_real;
    logic signed [VOLT_W-1:0] from_imag;
    logic signed [VOLT_W-1:0] to_real;
    logic signed [VOLT_W-1:0] to_imag;
    logic [FREQ_W-1:0]        from_frequency;
    logic [FREQ_W-1:0]        to_frequency;
    logic [STEP_W-1:0]        elapsed;
    logic                     last_phase;
    logic                     arm;
    logic                     first_iteration;
    logic                     post_pass;
  } scr_in_t;

  typedef struct packed {
    logic              close_switch;
    logic              armed_now;
    logic              within_limits;
    logic [TIME_W-1:0] held_time;
  } scr_out_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  frequency_limit;
    logic [VLIM_W-1:0]  voltage_limit;
    logic [VLIM2_W-1:0] voltage_limit_sq;
    logic [TIME_W-1:0]  hold_period;
    logic [2:0]         phase_enable;
  } scr_cfg_t;

endpackage

// ----- rtl/scr_in_if.sv -----
// Input item channel of the synchronism check relay.
interface scr_in_if;
  import scr_pkg::*;

  logic    valid;
  logic    ready;
  scr_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/scr_out_if.sv -----
// Result item channel of the synchronism check relay.
interface scr_out_if;
  import scr_pkg::*;

  logic     valid;
  logic     ready;
  scr_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/scr_regs.sv -----
// APB-style configuration registers of the synchronism check relay.
module scr_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scr_pkg::ADDR_W-1:0]   paddr,
  input  logic [scr_pkg::DATA_W-1:0]   pwdata,
  output logic [scr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output scr_pkg::scr_cfg_t            cfg
);
  import scr_pkg::*;

  scr_cfg_t cfg_r;
  scr_reg_t idx;
  logic     wr;

  assign idx    = scr_reg_t'(paddr[4:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frequency_limit  <= FREQ_LIMIT_RST;
      cfg_r.voltage_limit    <= VOLT_LIMIT_RST;
      cfg_r.voltage_limit_sq <= VOLT_LIMIT2_RST;
      cfg_r.hold_period      <= HOLD_PERIOD_RST;
      cfg_r.phase_enable     <= PHASE_ENABLE_RST;
    end else if (wr) begin
      case (idx)
        REG_FREQ_LIMIT: begin
          cfg_r.frequency_limit <= pwdata[FREQ_W-1:0];
        end
        REG_VOLT_LIMIT: begin
          cfg_r.voltage_limit    <= pwdata[VLIM_W-1:0];
          cfg_r.voltage_limit_sq <= VLIM2_W'(pwdata[VLIM_W-1:0])
                                    * VLIM2_W'(pwdata[VLIM_W-1:0]);
        end
        REG_HOLD_PERIOD: begin
          cfg_r.hold_period <= pwdata[TIME_W-1:0];
        end
        REG_PHASE_ENABLE: begin
          cfg_r.phase_enable <= pwdata[2:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FREQ_LIMIT:   prdata = DATA_W'(cfg_r.frequency_limit);
      REG_VOLT_LIMIT:   prdata = DATA_W'(cfg_r.voltage_limit);
      REG_HOLD_PERIOD:  prdata = DATA_W'(cfg_r.hold_period);
      REG_PHASE_ENABLE: prdata = DATA_W'(cfg_r.phase_enable);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/sync_check_relay.sv -----
// Top level of the synchronism check relay: four-stage item pipeline and state update.
// The block takes one item per clock cycle while the pipeline is not stalled, and
// returns one result for it through an input register, a register of squared phasor
// differences, a register of the limit compares and the result register, where the armed
// flag, the pass flags and the hold timer are updated. Backpressure on the result channel
// stalls the pipeline one stage at a time, so empty stages still take new items.
// Configuration registers sit at byte addresses 0, 8, 16 and 24 on a 64-bit data bus.
module sync_check_relay (
  input  logic                         clk,
  input  logic                         rst_n,
  scr_in_if.sink                       in_ch,
  scr_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [scr_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [scr_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [scr_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import scr_pkg::*;

  scr_cfg_t cfg;

  scr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Pipeline handshake.
  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic ld0, ld1, ld2, ld3;

  assign rdy3        = !v3_r || out_ch.ready;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = !v0_r || rdy1;
  assign ld0         = in_ch.valid && in_ch.ready;
  assign ld1         = v0_r && rdy1;
  assign ld2         = v1_r && rdy2;
  assign ld3         = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= ld0 || (v0_r && !rdy1);
      v1_r <= ld1 || (v1_r && !rdy2);
      v2_r <= ld2 || (v2_r && !rdy3);
      v3_r <= ld3 || (v3_r && !out_ch.ready);
    end
  end

  // Stage 0: input register.
  scr_in_t s0_r;

  always_ff @(posedge clk) begin
    if (ld0) begin
      s0_r <= in_ch.data;
    end
  end

  // Stage 1: squared differences, phase enable and frequency compare.
  logic signed [VOLT_W:0] dr, di;
  logic [VOLT_W:0]        dr_abs, di_abs;
  logic [2*VOLT_W+1:0]    dr_sq, di_sq;
  logic [FREQ_W-1:0]      fdiff;
  logic [3:0]             en_vec;

  assign dr     = {s0_r.from_real[VOLT_W-1], s0_r.from_real}
                - {s0_r.to_real[VOLT_W-1], s0_r.to_real};
  assign di     = {s0_r.from_imag[VOLT_W-1], s0_r.from_imag}
                - {s0_r.to_imag[VOLT_W-1], s0_r.to_imag};
  assign dr_abs = dr[VOLT_W] ? (VOLT_W+1)'(-dr) : (VOLT_W+1)'(dr);
  assign di_abs = di[VOLT_W] ? (VOLT_W+1)'(-di) : (VOLT_W+1)'(di);
  assign dr_sq  = (2*VOLT_W+2)'(dr_abs) * (2*VOLT_W+2)'(dr_abs);
  assign di_sq  = (2*VOLT_W+2)'(di_abs) * (2*VOLT_W+2)'(di_abs);
  assign fdiff  = (s0_r.from_frequency > s0_r.to_frequency)
                ? s0_r.from_frequency - s0_r.to_frequency
                : s0_r.to_frequency - s0_r.from_frequency;
  // The unused phase code maps to a cleared enable bit and always passes the voltage compare.
  assign en_vec = {1'b0, cfg.phase_enable};

  logic [SQ_W-1:0]   s1_dr2_r, s1_di2_r;
  logic              s1_hit_r, s1_fok_r, s1_last_r, s1_arm_r, s1_act_r;
  logic [STEP_W-1:0] s1_elapsed_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_dr2_r     <= dr_sq[SQ_W-1:0];
      s1_di2_r     <= di_sq[SQ_W-1:0];
      s1_hit_r     <= en_vec[s0_r.phase];
      s1_fok_r     <= fdiff <= cfg.frequency_limit;
      s1_last_r    <= s0_r.last_phase;
      s1_arm_r     <= s0_r.arm;
      s1_act_r     <= s0_r.first_iteration && !s0_r.post_pass;
      s1_elapsed_r <= s0_r.elapsed;
    end
  end

  // Stage 2: magnitude compare against the squared voltage limit.
  logic [SQ_W:0] mag2;

  assign mag2 = (SQ_W+1)'(s1_dr2_r) + (SQ_W+1)'(s1_di2_r);

  logic              s2_vfail_r, s2_fok_r, s2_last_r, s2_arm_r, s2_act_r;
  logic [STEP_W-1:0] s2_elapsed_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_vfail_r   <= s1_hit_r && (mag2 > (SQ_W+1)'(cfg.voltage_limit_sq));
      s2_fok_r     <= s1_fok_r;
      s2_last_r    <= s1_last_r;
      s2_arm_r     <= s1_arm_r;
      s2_act_r     <= s1_act_r;
      s2_elapsed_r <= s1_elapsed_r;
    end
  end

  // Stage 3: relay state and result register.
  logic              armed_r, phases_pass_r, metrics_ok_r;
  logic [TIME_W-1:0] hold_timer_r;
  logic              armed_nxt, phases_pass_nxt, metrics_ok_nxt, close_nxt;
  logic [TIME_W-1:0] hold_timer_nxt;
  logic [TIME_W:0]   sum;
  scr_out_t          s3_r;

  always_comb begin
    armed_nxt       = armed_r || s2_arm_r;
    phases_pass_nxt = s2_arm_r ? 1'b1 : phases_pass_r;
    metrics_ok_nxt  = s2_arm_r ? 1'b0 : metrics_ok_r;
    hold_timer_nxt  = s2_arm_r ? '0 : hold_timer_r;
    close_nxt       = 1'b0;
    sum             = (TIME_W+1)'(hold_timer_nxt) + (TIME_W+1)'(s2_elapsed_r);
    if (armed_nxt && s2_act_r) begin
      if (s2_vfail_r) begin
        phases_pass_nxt = 1'b0;
      end
      if (s2_last_r) begin
        metrics_ok_nxt = phases_pass_nxt && s2_fok_r;
        if (metrics_ok_nxt) begin
          hold_timer_nxt = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end else begin
          hold_timer_nxt = '0;
        end
        if (metrics_ok_nxt && (hold_timer_nxt >= cfg.hold_period)) begin
          close_nxt      = 1'b1;
          armed_nxt      = 1'b0;
          metrics_ok_nxt = 1'b0;
          hold_timer_nxt = '0;
        end
        phases_pass_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      phases_pass_r <= 1'b1;
      metrics_ok_r  <= 1'b0;
      hold_timer_r  <= '0;
    end else if (ld3) begin
      armed_r       <= armed_nxt;
      phases_pass_r <= phases_pass_nxt;
      metrics_ok_r  <= metrics_ok_nxt;
      hold_timer_r  <= hold_timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_r.close_switch  <= close_nxt;
      s3_r.armed_now     <= armed_nxt;
      s3_r.within_limits <= metrics_ok_nxt;
      s3_r.held_time     <= hold_timer_nxt;
    end
  end

  assign out_ch.valid = v3_r;
  assign out_ch.data  = s3_r;

  // A held timer only exists while the latest evaluation passed.
  a_timer_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !metrics_ok_r |-> (hold_timer_r == '0))
    else $error("hold timer nonzero without passing evaluation");

  // Passing metrics are only kept while the relay is armed.
  a_ok_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> !metrics_ok_r)
    else $error("metrics passing while disarmed");

  // A close result shows the relay disarmed with a cleared timer.
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && s3_r.close_switch) |->
      (!s3_r.armed_now && !s3_r.within_limits && (s3_r.held_time == '0)))
    else $error("close result with state not cleared");

  // The input side only stalls when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v0_r && v1_r && v2_r && v3_r))
    else $error("input stalled with an empty stage");

endmodule
